@@ rtl/core/rpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Readout packet deframer package
// Shared item types, result kinds and field constants for the deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

   // Storage for per-link word counts.
   localparam int LINK_SLOTS_DEF = 64;
   localparam int LANES          = 4;
   localparam int LEN_W          = 6;
   localparam int ROW_W          = LANES * LEN_W;

   // Channel words that carry no sample, counted from one at the first channel word.
   localparam logic [5:0] SKIP_FIRST  = 6'd19;
   localparam logic [5:0] SKIP_SECOND = 6'd20;

   // Word positions inside a subpacket.
   localparam logic [5:0] POS_CHIP   = 6'd0;
   localparam logic [5:0] POS_HEADER = 6'd2;
   localparam logic [5:0] POS_CHAN   = 6'd3;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_EVENT  = 3'd1,
      KIND_SUBHDR = 3'd2,
      KIND_SAMPLE = 3'd3,
      KIND_STRAY  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [31:0] packet_word;
      logic        first_word;
   } req_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  link_index;
      logic [15:0] source_id;
      logic [3:0]  format_version;
      logic [5:0]  link_count;
      logic [9:0]  orbit_count;
      logic [9:0]  request_count;
      logic [11:0] bunch_number;
      logic [7:0]  write_address;
      logic [5:0]  channel_index;
      logic [9:0]  adc_value;
      logic        end_of_packet;
   } rsp_item_type;

   // Outcome of the search for the next link that carries words.
   typedef struct packed {
      logic       found;
      logic [5:0] index;
   } seek_type;

endpackage

@@ rtl/core/readout_packet_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// Readout packet deframer
// Walks readout packets one 32-bit word per item and reports event headers,
// subpacket headers and ADC samples, one result item per input item.
//
//   Channel   Ports                          Moves
//   --------  -----------------------------  --------------------------------
//   request   req_valid req_stall req_item   packet word and first-word flag
//   response  rsp_valid rsp_stall rsp_item   tagged result, end-of-packet flag
//
// An item is accepted in every cycle while the skid register is empty; its
// result is registered on rsp_item, or in the skid register while rsp_stall is high.
// Per-link lengths sit in a RAM of four-link rows, re-read every cycle at the
// row of the current link. Reset is synchronous and clears the parser and the
// valid flags of both result registers; the length RAM is not cleared. A stalled
// response fills the skid register, after which req_stall rises until the response side drains.
// ----------------------------------------------------------------------------
module readout_packet_deframer_unit #(
   parameter int LINK_SLOTS = rpd_pkg::LINK_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rpd_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rpd_pkg::rsp_item_type rsp_item
);
   import rpd_pkg::*;

   localparam int ROWS   = (LINK_SLOTS + LANES - 1) / LANES;
   localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [4:0] ROWS_V = 5'(ROWS);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HDR2,
      PH_LEN,
      PH_SUB
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [5:0]            links_ff, links_in;
   logic [7:0]            fpga_ff, fpga_in;
   logic [3:0]            version_ff, version_in;
   logic [3:0]            seen_ff, seen_in;
   logic [5:0]            link_ff, link_in;
   logic [5:0]            pos_ff, pos_in;
   logic [5:0]            samples_ff, samples_in;
   logic [15:0]           chip_ff, chip_in;
   logic [LINK_SLOTS-1:0] nz_ff, nz_in;
   rsp_item_type          rsp_ff, skid_ff;
   logic                  rsp_valid_ff, skid_valid_ff;
   logic                  byp_ff, byp_in;
   logic [ROW_W-1:0]      byp_row_ff;

   rsp_item_type          res;
   logic                  accept, take;
   logic [31:0]           w;
   logic [ROW_W-1:0]      len_row_wr, ram_row, cur_row;
   logic [LEN_W-1:0]      len_cur;
   logic                  len_update, ram_we;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [6:0]            total_sum;
   logic [4:0]            seen_next;
   logic [6:0]            pos_next, seek_from;
   logic [5:0]            chan_count;
   seek_type              seek;

   assign w       = req_item.packet_word;
   assign accept  = req_valid && !req_stall;
   assign take    = rsp_valid_ff && !rsp_stall;

   assign len_row_wr = {w[29:24], w[21:16], w[13:8], w[5:0]};
   assign len_update = accept && !req_item.first_word && (phase_ff == PH_LEN);
   assign wr_addr    = ADDR_W'(seen_ff);
   assign ram_we     = len_update && ({1'b0, seen_ff} < ROWS_V);

   // Flags of links with a nonzero length, updated by the length word now
   // being taken so that the search below sees it.
   always_comb begin
      nz_in = nz_ff;
      for (int j = 0; j < LINK_SLOTS; j++) begin
         if (len_update && (4'(j >> 2) == seen_ff)) begin
            nz_in[j] = |len_row_wr[(j & 3) * LEN_W +: LEN_W];
         end
      end
   end

   assign seek_from = (phase_ff == PH_LEN) ? 7'd0 : ({1'b0, link_ff} + 7'd1);

   rpd_link_seek #(
      .LINK_SLOTS(LINK_SLOTS)
   ) u_seek (
      .nonzero(nz_in),
      .limit  (links_ff),
      .from   (seek_from),
      .seek   (seek)
   );

   rpd_ram #(
      .WIDTH(ROW_W),
      .DEPTH(ROWS)
   ) u_len_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_addr),
      .wr_data(len_row_wr),
      .rd_addr(rd_addr),
      .rd_data(ram_row)
   );

   // The row holding the current link is read every cycle; a write to that
   // row on the same edge is forwarded for one cycle.
   assign rd_addr = ADDR_W'(link_in[5:2]);
   assign byp_in  = ram_we && (wr_addr == rd_addr);
   assign cur_row = byp_ff ? byp_row_ff : ram_row;
   assign len_cur = cur_row[link_ff[1:0] * LEN_W +: LEN_W];

   assign total_sum  = {1'b0, links_ff} + 7'd3;
   assign seen_next  = {1'b0, seen_ff} + 5'd1;
   assign pos_next   = {1'b0, pos_ff} + 7'd1;
   assign chan_count = pos_ff - 6'd2;

   always_comb begin
      phase_in   = phase_ff;
      links_in   = links_ff;
      fpga_in    = fpga_ff;
      version_in = version_ff;
      seen_in    = seen_ff;
      link_in    = link_ff;
      pos_in     = pos_ff;
      samples_in = samples_ff;
      chip_in    = chip_ff;
      res        = '0;
      res.kind   = KIND_NONE;

      if (accept) begin
         if (req_item.first_word) begin
            links_in   = w[19:14];
            fpga_in    = w[27:20];
            version_in = w[31:28];
            seen_in    = '0;
            link_in    = '0;
            pos_in     = '0;
            samples_in = '0;
            phase_in   = PH_HDR2;
         end else begin
            case (phase_ff)
               PH_HDR2: begin
                  res.kind           = KIND_EVENT;
                  res.source_id      = {8'd0, fpga_ff};
                  res.format_version = version_ff;
                  res.link_count     = links_ff;
                  res.orbit_count    = w[9:0];
                  res.request_count  = w[19:10];
                  res.bunch_number   = w[31:20];
                  seen_in            = '0;
                  if (links_ff == 6'd0) begin
                     phase_in          = PH_IDLE;
                     res.end_of_packet = 1'b1;
                  end else begin
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  seen_in = seen_next[3:0];
                  if (seen_next >= total_sum[6:2]) begin
                     if (seek.found) begin
                        link_in    = seek.index;
                        pos_in     = '0;
                        samples_in = '0;
                        phase_in   = PH_SUB;
                     end else begin
                        phase_in          = PH_IDLE;
                        res.end_of_packet = 1'b1;
                     end
                  end
               end
               PH_SUB: begin
                  if (pos_ff == POS_CHIP) begin
                     chip_in = w[31:16];
                  end else if (pos_ff == POS_HEADER) begin
                     res.kind          = KIND_SUBHDR;
                     res.link_index    = link_ff;
                     res.source_id     = chip_ff;
                     res.bunch_number  = w[24:13];
                     res.write_address = w[11:4];
                  end else if (pos_ff >= POS_CHAN) begin
                     if (chan_count != SKIP_FIRST && chan_count != SKIP_SECOND) begin
                        res.kind          = KIND_SAMPLE;
                        res.link_index    = link_ff;
                        res.channel_index = samples_ff;
                        res.adc_value     = w[9:0];
                        samples_in        = samples_ff + 6'd1;
                     end
                  end
                  pos_in = pos_next[5:0];
                  if (pos_next >= {1'b0, len_cur}) begin
                     if (seek.found) begin
                        link_in    = seek.index;
                        pos_in     = '0;
                        samples_in = '0;
                     end else begin
                        phase_in          = PH_IDLE;
                        res.end_of_packet = 1'b1;
                     end
                  end
               end
               default: begin
                  res.kind = KIND_STRAY;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         links_ff      <= '0;
         seen_ff       <= '0;
         link_ff       <= '0;
         pos_ff        <= '0;
         samples_ff    <= '0;
         nz_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         byp_ff        <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         links_ff   <= links_in;
         seen_ff    <= seen_in;
         link_ff    <= link_in;
         pos_ff     <= pos_in;
         samples_ff <= samples_in;
         nz_ff      <= nz_in;
         byp_ff     <= byp_in;
         if (take || !rsp_valid_ff) begin
            rsp_valid_ff  <= skid_valid_ff || accept;
            skid_valid_ff <= 1'b0;
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
      fpga_ff    <= fpga_in;
      version_ff <= version_in;
      chip_ff    <= chip_in;
      byp_row_ff <= len_row_wr;
      if (take || !rsp_valid_ff) begin
         rsp_ff <= skid_valid_ff ? skid_ff : res;
      end else if (accept) begin
         skid_ff <= res;
      end
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds an item while the output register is empty");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_stall))
      else $error("skid register filled without a stalled response");

   a_link_announced: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SUB) |-> (link_ff < links_ff))
      else $error("walking a link beyond the announced count");

   a_pos_in_subpacket: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SUB) |-> ({1'b0, pos_ff} < {1'b0, len_cur}))
      else $error("subpacket word position has run past the link length");

endmodule

@@ rtl/core/rpd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rpd_ram #(
   parameter  int WIDTH  = 24,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/rpd_link_seek.sv @@
// ----------------------------------------------------------------------------
// Next-link finder
// Picks the lowest announced link at or after a start point whose length is
// nonzero, by isolating the lowest set bit of the candidate vector.
// ----------------------------------------------------------------------------
module rpd_link_seek #(
   parameter int LINK_SLOTS = rpd_pkg::LINK_SLOTS_DEF
) (
   input  logic [LINK_SLOTS-1:0] nonzero,
   input  logic [5:0]            limit,
   input  logic [6:0]            from,
   output rpd_pkg::seek_type     seek
);
   import rpd_pkg::*;

   logic [LINK_SLOTS-1:0] cand;
   logic [LINK_SLOTS-1:0] lowest;
   logic [5:0]            index;

   always_comb begin
      for (int j = 0; j < LINK_SLOTS; j++) begin
         cand[j] = nonzero[j] && (6'(j) < limit) && (7'(j) >= from);
      end
   end

   assign lowest = cand & (~cand + LINK_SLOTS'(1));

   always_comb begin
      index = '0;
      for (int j = 0; j < LINK_SLOTS; j++) begin
         if (lowest[j]) begin
            index = index | 6'(j);
         end
      end
   end

   assign seek.found = |cand;
   assign seek.index = index;

endmodule
